/* rtl/core/asfp_pkg.sv */
// Shared types and constants for the ASCII sensor frame parser.
// Used by the front end, the frame queue, the back end and the top level.
// No dependencies.
package asfp_pkg;

  // Depth of the frame buffer; write_index saturates here.
  localparam int BUFFER_DEPTH = 40;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH + 1);

  // Only the first NUM_POS byte positions are ever looked at by classification.
  localparam int NUM_POS    = 15;
  localparam int NUM_DIGITS = 8;
  localparam int VALUE_W    = 33;

  // Frame positions of the digits, lowest index is the most significant digit.
  localparam int DIGIT_POS [NUM_DIGITS] = '{6, 7, 8, 9, 10, 11, 13, 14};

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h2A;  // '*'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
  localparam logic [7:0] CH_LOW_T = 8'h74;  // 't'
  localparam logic [7:0] CH_LOW_R = 8'h72;  // 'r'
  localparam logic [7:0] CH_LOW_H = 8'h68;  // 'h'
  localparam logic [7:0] CH_LOW_G = 8'h67;  // 'g'
  localparam logic [7:0] CH_UP_C  = 8'h43;  // 'C'

  typedef enum logic [2:0] {
    KIND_TEMP1   = 3'd0,
    KIND_PRES1   = 3'd1,
    KIND_HUMI1   = 3'd2,
    KIND_GAS_RES = 3'd3,
    KIND_HUMI2   = 3'd4,
    KIND_TEMP2   = 3'd5,
    KIND_CO2     = 3'd6,
    KIND_GAS1    = 3'd7
  } kind_t;

  // A classified frame on its way from the front end to the back end.
  typedef struct packed {
    kind_t                     kind;
    logic [NUM_DIGITS-1:0][7:0] digit;
  } frame_rec_t;

endpackage

/* rtl/core/asfp_front.sv */
// Front end of the ASCII sensor frame parser: byte capture, frame buffer and
// classification of a finished frame. Depends on asfp_pkg.
module asfp_front import asfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] rx_byte,
  output logic       full,
  input  logic       fq_full,
  output logic       rec_push,
  output frame_rec_t rec
);

  logic             capture_on;
  logic [IDX_W-1:0] write_index;
  logic [7:0]       frame_byte [NUM_POS];

  logic       accept;
  logic       capture_now;
  logic       store;
  logic       is_end;
  logic       hit;
  kind_t      kind;
  logic [7:0] view [NUM_POS];

  assign full        = fq_full;
  assign accept      = push && !full;
  assign capture_now = capture_on || (rx_byte == CH_START);
  assign store       = capture_now && (write_index < IDX_W'(BUFFER_DEPTH));
  assign is_end      = rx_byte == CH_END;

  // The buffer as it stands once this byte has been written, so that a
  // closing '*' that lands on a tracked position is seen by classification.
  always_comb begin
    for (int p = 0; p < NUM_POS; p++) begin
      view[p] = (store && (write_index == IDX_W'(p))) ? rx_byte : frame_byte[p];
    end
  end

  always_comb begin
    hit  = 1'b1;
    kind = KIND_TEMP1;
    if (view[1] == CH_LOW_T && view[5] == CH_ONE) begin
      kind = KIND_TEMP1;
    end else if (view[2] == CH_LOW_R && view[5] == CH_ONE) begin
      kind = KIND_PRES1;
    end else if (view[1] == CH_LOW_H && view[5] == CH_ONE) begin
      kind = KIND_HUMI1;
    end else if (view[1] == CH_LOW_G) begin
      kind = KIND_GAS_RES;
    end else if (view[1] == CH_LOW_H && view[5] == CH_TWO) begin
      kind = KIND_HUMI2;
    end else if (view[1] == CH_LOW_T && view[5] == CH_TWO) begin
      kind = KIND_TEMP2;
    end else if (view[1] == CH_UP_C) begin
      kind = KIND_CO2;
    end else if (view[2] == CH_LOW_G && view[5] == CH_ONE) begin
      kind = KIND_GAS1;
    end else begin
      hit = 1'b0;
    end
  end

  always_comb begin
    rec.kind = kind;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      rec.digit[j] = view[DIGIT_POS[j]];
    end
  end

  // Frames that match no kind never leave the front end.
  assign rec_push = accept && capture_now && is_end && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_on  <= 1'b0;
      write_index <= '0;
      for (int p = 0; p < NUM_POS; p++) begin
        frame_byte[p] <= '0;
      end
    end else if (accept) begin
      if (!capture_now) begin
        write_index <= '0;
      end else begin
        frame_byte <= view;
        if (is_end) begin
          capture_on  <= 1'b0;
          write_index <= '0;
        end else begin
          capture_on <= 1'b1;
          if (store) begin
            write_index <= write_index + IDX_W'(1);
          end
        end
      end
    end
  end

endmodule

/* rtl/core/asfp_frame_queue.sv */
// Two-entry queue of classified frames between the front and back ends.
// Depends on asfp_pkg.
module asfp_frame_queue import asfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output frame_rec_t pop_rec
);

  frame_rec_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/asfp_back.sv */
// Back end of the ASCII sensor frame parser: digit weighting, a two-level
// adder pipeline and the two-entry result queue. Depends on asfp_pkg.
module asfp_back import asfp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fq_empty,
  input  frame_rec_t                fq_rec,
  output logic                      fq_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [2:0]                record_kind,
  output logic signed [VALUE_W-1:0] value_hundredths
);

  typedef enum logic [1:0] {
    FMT_SMALL_FRAC = 2'd0,
    FMT_LARGE_FRAC = 2'd1,
    FMT_SMALL_INT  = 2'd2,
    FMT_LARGE_INT  = 2'd3
  } fmt_t;

  localparam int WEIGHT_W = 24;

  // Digit weights per layout, in the order of DIGIT_POS.
  localparam logic [WEIGHT_W-1:0] WEIGHT [4][NUM_DIGITS] = '{
    '{24'd10000, 24'd1000, 24'd100, 24'd0, 24'd10, 24'd1, 24'd0, 24'd0},
    '{24'd10000000, 24'd1000000, 24'd100000, 24'd10000,
      24'd1000, 24'd100, 24'd10, 24'd1},
    '{24'd10000, 24'd1000, 24'd100, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0},
    '{24'd10000000, 24'd1000000, 24'd100000, 24'd10000,
      24'd1000, 24'd100, 24'd0, 24'd0}
  };

  function automatic fmt_t fmt_of(kind_t k);
    fmt_t f;
    case (k)
      KIND_TEMP1, KIND_HUMI1:   f = FMT_SMALL_FRAC;
      KIND_PRES1, KIND_GAS_RES: f = FMT_LARGE_FRAC;
      KIND_HUMI2, KIND_TEMP2:   f = FMT_SMALL_INT;
      KIND_CO2, KIND_GAS1:      f = FMT_LARGE_INT;
      default:                  f = FMT_SMALL_FRAC;
    endcase
    return f;
  endfunction

  fmt_t                      fmt;
  logic signed [8:0]         dig [NUM_DIGITS];
  logic signed [VALUE_W-1:0] dx [NUM_DIGITS];
  logic signed [VALUE_W-1:0] term [NUM_DIGITS];

  logic                      s1_valid;
  kind_t                     s1_kind;
  logic signed [VALUE_W-1:0] s1_term [NUM_DIGITS];
  logic                      s1_ready;

  logic                      s2_valid;
  kind_t                     s2_kind;
  logic signed [VALUE_W-1:0] s2_sum_a;
  logic signed [VALUE_W-1:0] s2_sum_b;
  logic                      s2_ready;

  kind_t                     oq_kind [2];
  logic signed [VALUE_W-1:0] oq_value [2];
  logic                      oq_wr;
  logic                      oq_rd;
  logic [1:0]                oq_count;
  logic                      oq_full;
  logic                      oq_push;
  logic                      oq_pop;

  // Each layout gets its own constant multiplier; the layout only selects.
  always_comb begin
    fmt = fmt_of(fq_rec.kind);
    for (int j = 0; j < NUM_DIGITS; j++) begin
      dig[j] = $signed({1'b0, fq_rec.digit[j]}) - $signed({1'b0, CH_ZERO});
      dx[j]  = {{(VALUE_W - 9){dig[j][8]}}, dig[j]};
      case (fmt)
        FMT_SMALL_FRAC:
          term[j] = dx[j] * $signed({{(VALUE_W - WEIGHT_W){1'b0}},
                                     WEIGHT[FMT_SMALL_FRAC][j]});
        FMT_LARGE_FRAC:
          term[j] = dx[j] * $signed({{(VALUE_W - WEIGHT_W){1'b0}},
                                     WEIGHT[FMT_LARGE_FRAC][j]});
        FMT_SMALL_INT:
          term[j] = dx[j] * $signed({{(VALUE_W - WEIGHT_W){1'b0}},
                                     WEIGHT[FMT_SMALL_INT][j]});
        FMT_LARGE_INT:
          term[j] = dx[j] * $signed({{(VALUE_W - WEIGHT_W){1'b0}},
                                     WEIGHT[FMT_LARGE_INT][j]});
        default: term[j] = '0;
      endcase
    end
  end

  assign oq_full  = oq_count == 2'd2;
  assign empty    = oq_count == 2'd0;
  assign oq_push  = s2_valid && !oq_full;
  assign oq_pop   = pop && !empty;
  assign s2_ready = !s2_valid || !oq_full;
  assign s1_ready = !s1_valid || s2_ready;
  assign fq_pop   = !fq_empty && s1_ready;

  assign record_kind      = oq_kind[oq_rd];
  assign value_hundredths = oq_value[oq_rd];

  always_ff @(posedge clk) begin
    if (fq_pop) begin
      s1_kind <= fq_rec.kind;
      s1_term <= term;
    end
    if (s1_valid && s2_ready) begin
      s2_kind  <= s1_kind;
      s2_sum_a <= s1_term[0] + s1_term[1] + s1_term[2] + s1_term[3];
      s2_sum_b <= s1_term[4] + s1_term[5] + s1_term[6] + s1_term[7];
    end
    if (oq_push) begin
      oq_kind[oq_wr]  <= s2_kind;
      oq_value[oq_wr] <= s2_sum_a + s2_sum_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid <= !fq_empty;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (oq_push) begin
        oq_wr <= !oq_wr;
      end
      if (oq_pop) begin
        oq_rd <= !oq_rd;
      end
      case ({oq_push, oq_pop})
        2'b10:   oq_count <= oq_count + 2'd1;
        2'b01:   oq_count <= oq_count - 2'd1;
        default: oq_count <= oq_count;
      endcase
    end
  end

endmodule

/* rtl/core/ascii_sensor_frame_parser.sv */
// Top level of the ASCII sensor frame parser: front end, frame queue and
// back end. Depends on asfp_pkg, asfp_front, asfp_frame_queue and asfp_back.
//
//   Channel   Handshake         Payload
//   bytes in  push / full       rx_byte[7:0]
//   results   pop / empty       record_kind[2:0], value_hundredths[32:0]
//
// One byte is taken per cycle while full is low. A closing '*' that
// completes a recognized frame reaches the results through the frame
// queue, weighting stage, adder stage and result queue. Reset clears
// capture state, the frame buffer and both queues. full rises only when the
// two-entry frame queue is full, which happens only when results back up.
module ascii_sensor_frame_parser import asfp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                rx_byte,
  output logic                      empty,
  input  logic                      pop,
  output logic [2:0]                record_kind,
  output logic signed [VALUE_W-1:0] value_hundredths
);

  logic       fq_full;
  logic       fq_empty;
  logic       fq_push;
  logic       fq_pop;
  frame_rec_t front_rec;
  frame_rec_t queue_rec;

  asfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rx_byte  (rx_byte),
    .full     (full),
    .fq_full  (fq_full),
    .rec_push (fq_push),
    .rec      (front_rec)
  );

  asfp_frame_queue u_frame_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fq_push),
    .push_rec (front_rec),
    .full     (fq_full),
    .pop      (fq_pop),
    .empty    (fq_empty),
    .pop_rec  (queue_rec)
  );

  asfp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .fq_empty         (fq_empty),
    .fq_rec           (queue_rec),
    .fq_pop           (fq_pop),
    .empty            (empty),
    .pop              (pop),
    .record_kind      (record_kind),
    .value_hundredths (value_hundredths)
  );

endmodule

/* test/asfp_checker.sv */
// Scoreboard for the ASCII sensor frame parser: mirrors the frame buffer from
// accepted bytes, predicts each decoded reading and checks the result queue.
// Depends on asfp_pkg.
module asfp_checker import asfp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  logic [7:0]                rx_byte,
  input  logic                      empty,
  input  logic                      pop,
  input  logic [2:0]                record_kind,
  input  logic signed [VALUE_W-1:0] value_hundredths,
  output int                        pending,
  output int                        fail_count
);

  typedef struct {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value;
  } reading_t;

  reading_t    readings_due[$];
  logic        capturing;
  int unsigned wr_idx;
  logic [7:0]  frame_buf [BUFFER_DEPTH];
  int          errs = 0;

  // Digits are taken as raw byte minus '0', so any byte value contributes.
  function automatic longint digit_at(input int p);
    return longint'(frame_buf[p]) - longint'(CH_ZERO);
  endfunction

  function automatic longint weigh_digits(input kind_t k);
    longint hi_part;
    hi_part = 10000 * digit_at(6) + 1000 * digit_at(7) + 100 * digit_at(8);
    case (k)
      KIND_TEMP1, KIND_HUMI1: begin
        return hi_part + 10 * digit_at(10) + digit_at(11);
      end
      KIND_HUMI2, KIND_TEMP2: begin
        return hi_part;
      end
      KIND_PRES1, KIND_GAS_RES: begin
        return 1000 * hi_part + 10000 * digit_at(9) + 1000 * digit_at(10)
               + 100 * digit_at(11) + 10 * digit_at(13) + digit_at(14);
      end
      default: begin
        return 1000 * hi_part + 10000 * digit_at(9) + 1000 * digit_at(10)
               + 100 * digit_at(11);
      end
    endcase
  endfunction

  // First match wins; returns 0 when the frame is of no known kind.
  function automatic bit classify_frame(output kind_t k);
    logic [7:0] b1, b2, b5;
    b1 = frame_buf[1];
    b2 = frame_buf[2];
    b5 = frame_buf[5];
    k  = KIND_TEMP1;
    if (b1 == CH_LOW_T && b5 == CH_ONE)      k = KIND_TEMP1;
    else if (b2 == CH_LOW_R && b5 == CH_ONE) k = KIND_PRES1;
    else if (b1 == CH_LOW_H && b5 == CH_ONE) k = KIND_HUMI1;
    else if (b1 == CH_LOW_G)                 k = KIND_GAS_RES;
    else if (b1 == CH_LOW_H && b5 == CH_TWO) k = KIND_HUMI2;
    else if (b1 == CH_LOW_T && b5 == CH_TWO) k = KIND_TEMP2;
    else if (b1 == CH_UP_C)                  k = KIND_CO2;
    else if (b2 == CH_LOW_G && b5 == CH_ONE) k = KIND_GAS1;
    else return 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : track
    reading_t due;
    kind_t    k;
    longint   sum;
    if (rst) begin
      capturing = 1'b0;
      wr_idx    = 0;
      for (int i = 0; i < BUFFER_DEPTH; i++) frame_buf[i] = 8'h00;
      readings_due.delete();
    end else begin
      if (pop && !empty) begin
        if (readings_due.size() == 0) begin
          $error("unexpected result: record_kind %0d value_hundredths %0d",
                 record_kind, value_hundredths);
          errs++;
        end else begin
          due = readings_due.pop_front();
          if (record_kind !== due.kind) begin
            $error("record_kind: expected %0d, got %0d", due.kind, record_kind);
            errs++;
          end
          if (value_hundredths !== due.value) begin
            $error("value_hundredths: expected %0d, got %0d", due.value,
                   value_hundredths);
            errs++;
          end
        end
      end
      if (push && !full) begin
        if (rx_byte == CH_START) capturing = 1'b1;
        if (!capturing) begin
          wr_idx = 0;
        end else begin
          // Once the buffer is full, further bytes are dropped.
          if (wr_idx < BUFFER_DEPTH) begin
            frame_buf[wr_idx] = rx_byte;
            wr_idx++;
          end
          if (rx_byte == CH_END) begin
            capturing = 1'b0;
            wr_idx    = 0;
            if (classify_frame(k)) begin
              sum       = weigh_digits(k);
              due.kind  = k;
              due.value = sum[VALUE_W-1:0];
              readings_due.push_back(due);
            end
          end
        end
      end
    end
    pending    <= readings_due.size();
    fail_count <= errs;
  end

endmodule

/* test/tb_top.sv */
// Testbench top for the ASCII sensor frame parser: drives serial bytes and
// result pops with random idling, and reports the verdict.
// Depends on asfp_pkg, ascii_sensor_frame_parser and asfp_checker.
module tb_top import asfp_pkg::*; ();

  localparam int TARGET_BYTES = 1150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      pop = 1'b0;
  logic [7:0]                rx_byte = 8'h00;
  logic                      full;
  logic                      empty;
  logic [2:0]                record_kind;
  logic signed [VALUE_W-1:0] value_hundredths;

  int pending;
  int fail_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  ascii_sensor_frame_parser dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .rx_byte          (rx_byte),
    .empty            (empty),
    .pop              (pop),
    .record_kind      (record_kind),
    .value_hundredths (value_hundredths)
  );

  asfp_checker frame_check (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .rx_byte          (rx_byte),
    .empty            (empty),
    .pop              (pop),
    .record_kind      (record_kind),
    .value_hundredths (value_hundredths),
    .pending          (pending),
    .fail_count       (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** ascii_sensor_frame_parser: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Holds the byte until the transaction is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_END) b = CH_ZERO;
    return b;
  endfunction

  function automatic logic [7:0] digit_byte();
    int r;
    r = $urandom_range(99);
    if (r < 80) return CH_ZERO + 8'($urandom_range(9));
    if (r < 85) return 8'h00;
    if (r < 90) return 8'hFF;
    return text_byte();
  endfunction

  task automatic send_frame();
    logic [7:0] body[$];
    logic [7:0] fill;
    int         style;
    int         len;
    style = $urandom_range(99);
    body.push_back(CH_START);
    case ($urandom_range(4))
      0:       body.push_back(CH_LOW_T);
      1:       body.push_back(CH_LOW_H);
      2:       body.push_back(CH_LOW_G);
      3:       body.push_back(CH_UP_C);
      default: body.push_back(text_byte());
    endcase
    case ($urandom_range(2))
      0:       body.push_back(CH_LOW_R);
      1:       body.push_back(CH_LOW_G);
      default: body.push_back(text_byte());
    endcase
    body.push_back(text_byte());
    body.push_back(text_byte());
    case ($urandom_range(2))
      0:       body.push_back(CH_ONE);
      1:       body.push_back(CH_TWO);
      default: body.push_back(text_byte());
    endcase
    // Mostly plain digits; a few frames carry the all-low or all-high extreme.
    fill = ($urandom_range(1)) ? 8'hFF : 8'h00;
    for (int p = 6; p < 15; p++) body.push_back((style >= 94) ? fill : digit_byte());
    if (style < 10) begin
      // Short frame: the classifier reads stale bytes left by earlier frames.
      len  = $urandom_range(1, 14);
      body = body[0:len-1];
    end else if (style < 18) begin
      repeat ($urandom_range(26, 45)) body.push_back(text_byte());
    end else begin
      repeat ($urandom_range(0, 4)) body.push_back(text_byte());
    end
    if (style >= 18 && style < 24) body[$urandom_range(1, body.size() - 1)] = CH_START;
    // A frame now and then is left open so the next '$' lands mid-capture.
    if (style < 91 || style >= 94) body.push_back(CH_END);
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    send_idle_pct = 12;
    recv_idle_pct = 76;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Bytes outside a frame are ignored.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Pressure frame with the highest digit bytes everywhere.
    send_byte(CH_START);
    send_byte(CH_LOW_G);
    send_byte(CH_LOW_R);
    send_byte(CH_ZERO);
    send_byte(CH_ZERO);
    send_byte(CH_ONE);
    repeat (9) send_byte(8'hFF);
    send_byte(CH_END);
    // Short frame: the terminator overwrites byte two, digits are stale.
    send_byte(CH_START);
    send_byte(CH_LOW_G);
    send_byte(CH_END);
    // A second start inside a frame is stored as data.
    send_byte(CH_START);
    send_byte(CH_UP_C);
    send_byte(CH_START);
    send_byte(CH_END);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (bytes_sent < (phase + 1) * TARGET_BYTES / 3) begin
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(1, 3)) send_byte(text_byte() ^ 8'($urandom_range(1)));
        end
        send_frame();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** ascii_sensor_frame_parser: PASSED **");
    end else begin
      $display("** ascii_sensor_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule
